// ----- src/grid_bfs_limited_knight_jumps_assert.svh -----
// Assertion macros for the knight-jump grid search block.
`ifndef GRID_BFS_LIMITED_KNIGHT_JUMPS_ASSERT_SVH
`define GRID_BFS_LIMITED_KNIGHT_JUMPS_ASSERT_SVH
`ifndef SYNTHESIS
`define GBKJ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");
`define GBKJ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");
`else
`define GBKJ_ASSERT_NOW(lbl, ante, cons)
`define GBKJ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/gbkj_pkg.sv -----
// Shared types, register codes and move tables of the knight-jump grid search.
package gbkj_pkg;

    typedef logic [1:0] t_cfg_idx;
    typedef logic [3:0] t_move;

    localparam t_cfg_idx CFG_JUMP_LIMIT = 2'd0;
    localparam t_cfg_idx CFG_GRID_COLS  = 2'd1;
    localparam t_cfg_idx CFG_GRID_ROWS  = 2'd2;

    // Moves 0 to 7 are knight jumps, 8 to 11 are the four neighbor steps.
    localparam t_move NUM_KNIGHT = 4'd8;
    localparam t_move LAST_MOVE  = 4'd11;

    function automatic logic signed [2:0] move_dr(input t_move m);
        logic signed [2:0] v;
        case (m)
            4'd0: v = 3'sd1;
            4'd1: v = 3'sd2;
            4'd2: v = 3'sd2;
            4'd3: v = 3'sd1;
            4'd4: v = -3'sd1;
            4'd5: v = -3'sd2;
            4'd6: v = -3'sd2;
            4'd7: v = -3'sd1;
            4'd8: v = 3'sd1;
            4'd10: v = -3'sd1;
            default: v = 3'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [2:0] move_dc(input t_move m);
        logic signed [2:0] v;
        case (m)
            4'd0: v = 3'sd2;
            4'd1: v = 3'sd1;
            4'd2: v = -3'sd1;
            4'd3: v = -3'sd2;
            4'd4: v = -3'sd2;
            4'd5: v = -3'sd1;
            4'd6: v = 3'sd1;
            4'd7: v = 3'sd2;
            4'd9: v = 3'sd1;
            4'd11: v = -3'sd1;
            default: v = 3'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/gbkj_ram.sv -----
// Simple dual-port memory with one write port and one registered read port.
module gbkj_ram #(
    parameter int DEPTH = 2,
    parameter int AW    = 1,
    parameter int DW    = 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/gbkj_move_unit.sv -----
// Shared move unit: applies one move offset, checks the grid bounds and forms the map row base.
module gbkj_move_unit #(
    parameter int RW = 6,
    parameter int CW = 6
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [RW-1:0]        i_row,
    input  logic [CW-1:0]        i_col,
    input  gbkj_pkg::t_move      i_move,
    input  logic [RW:0]          i_rows,
    input  logic [CW:0]          i_cols,
    output logic                 o_ok,
    output logic [RW-1:0]        o_row,
    output logic [CW-1:0]        o_col,
    output logic [RW+CW:0]       o_prod
);
    import gbkj_pkg::*;

    logic signed [RW+1:0] nr;
    logic signed [CW+1:0] nc;
    logic                 ok;
    logic                 r_ok;
    logic [RW-1:0]        r_row;
    logic [CW-1:0]        r_col;
    logic [RW+CW:0]       r_prod;

    always_comb begin
        nr = $signed({2'b00, i_row}) + (RW+2)'(move_dr(i_move));
        nc = $signed({2'b00, i_col}) + (CW+2)'(move_dc(i_move));
        ok = (nr >= 0) && (nr < $signed({1'b0, i_rows}))
            && (nc >= 0) && (nc < $signed({1'b0, i_cols}));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok   <= ok;
            r_row  <= nr[RW-1:0];
            r_col  <= nc[CW-1:0];
            r_prod <= (RW+CW+1)'(nr[RW-1:0]) * (RW+CW+1)'(i_cols);
        end
    end

    assign o_ok   = r_ok;
    assign o_row  = r_row;
    assign o_col  = r_col;
    assign o_prod = r_prod;
endmodule

// ----- src/grid_bfs_limited_knight_jumps.sv -----
// Top level of the breadth-first grid search with a limited number of knight jumps.
// Map beats are taken one per cycle while the block is in its load state.
// The last beat starts a search: a clearing pass over the whole distance store, a seed step,
// then for each dequeued state a pop, a distance read and the moves tried (12 below the jump
// limit, 4 in the top layer), then a scan of the target cell in each layer up to the limit and
// the posting of the result once the output register is free. Reset is synchronous, active low.
`include "grid_bfs_limited_knight_jumps_assert.svh"
module grid_bfs_limited_knight_jumps #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int MAX_LAYERS = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cell_blocked,
    input  logic               i_last_cell,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [17:0] o_min_moves,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  gbkj_pkg::t_cfg_idx i_cfg_index,
    input  logic [6:0]         i_cfg_data
);
    import gbkj_pkg::*;

    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LW     = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int AW     = LW + RW + CW;
    localparam int DDEPTH = MAX_LAYERS * (1 << (RW + CW));
    localparam int QD     = MAX_LAYERS * MAX_ROWS * MAX_COLS;
    localparam int QIW    = (QD > 1) ? $clog2(QD) : 1;
    localparam int QPW    = $clog2(QD + 1);
    localparam int DW     = QPW;
    localparam int PLANE  = MAX_ROWS * MAX_COLS;
    localparam int MW     = (PLANE > 1) ? $clog2(PLANE) : 1;
    localparam int LPW    = $clog2(PLANE + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_CLR, S_INIT, S_POP, S_POPW, S_BASE, S_CAND, S_MAP, S_CHK,
        S_SCAN, S_SCANW, S_DONE
    } t_state;

    // Configuration registers. Writes are to arrive only while the block is idle; the block does not enforce this.
    logic [4:0] r_jump_limit;
    logic [6:0] r_grid_cols;
    logic [6:0] r_grid_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_limit <= 5'd0;
            r_grid_cols  <= 7'd64;
            r_grid_rows  <= 7'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_JUMP_LIMIT: r_jump_limit <= i_cfg_data[4:0];
                CFG_GRID_COLS:  r_grid_cols  <= i_cfg_data;
                CFG_GRID_ROWS:  r_grid_rows  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // The grid size and jump limit are saturated into the range the memories hold.
    logic [RW:0]   rows_eff;
    logic [CW:0]   cols_eff;
    logic [LW-1:0] limit_eff;

    always_comb begin
        if (r_grid_rows == 7'd0) begin
            rows_eff = (RW+1)'(1);
        end else if (32'(r_grid_rows) > MAX_ROWS) begin
            rows_eff = (RW+1)'(MAX_ROWS);
        end else begin
            rows_eff = (RW+1)'(r_grid_rows);
        end
        if (r_grid_cols == 7'd0) begin
            cols_eff = (CW+1)'(1);
        end else if (32'(r_grid_cols) > MAX_COLS) begin
            cols_eff = (CW+1)'(MAX_COLS);
        end else begin
            cols_eff = (CW+1)'(r_grid_cols);
        end
        if (32'(r_jump_limit) > MAX_LAYERS - 1) begin
            limit_eff = LW'(MAX_LAYERS - 1);
        end else begin
            limit_eff = LW'(r_jump_limit);
        end
    end

    // Sequencer registers.
    t_state          r_state, n_state;
    logic [LPW-1:0]  r_load_pos, n_load_pos;
    logic [AW-1:0]   r_clr, n_clr;
    logic [QPW-1:0]  r_head, n_head;
    logic [QPW-1:0]  r_tail, n_tail;
    logic [AW-1:0]   r_cur, n_cur;
    logic [DW-1:0]   r_base, n_base;
    t_move           r_move, n_move;
    logic [AW-1:0]   r_cand, n_cand;
    logic [LW-1:0]   r_scan_l, n_scan_l;
    logic [DW-1:0]   r_best, n_best;
    logic            r_out_valid, n_out_valid;
    logic [17:0]     r_min_moves, n_min_moves;

    // Memory ports.
    logic            map_we;
    logic [MW-1:0]   map_waddr, map_raddr;
    logic            map_rdata;
    logic            dist_we;
    logic [AW-1:0]   dist_waddr, dist_raddr;
    logic [DW-1:0]   dist_wdata, dist_rdata;
    logic            q_we;
    logic [QIW-1:0]  q_waddr, q_raddr;
    logic [AW-1:0]   q_wdata, q_rdata;

    // Move unit.
    logic            mv_en;
    logic            mv_ok;
    logic [RW-1:0]   mv_row;
    logic [CW-1:0]   mv_col;
    logic [RW+CW:0]  mv_prod;

    logic [LW-1:0]   cur_layer;
    logic [RW-1:0]   cur_row;
    logic [CW-1:0]   cur_col;
    logic [LW-1:0]   cand_layer;
    logic            in_fire;

    assign cur_layer = r_cur[AW-1 -: LW];
    assign cur_row   = r_cur[RW+CW-1:CW];
    assign cur_col   = r_cur[CW-1:0];
    assign cand_layer = (r_move < NUM_KNIGHT) ? LW'(cur_layer + 1'b1) : cur_layer;
    assign in_fire   = i_in_valid && o_in_ready;

    gbkj_ram #(.DEPTH(PLANE), .AW(MW), .DW(1)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr), .i_wdata(i_cell_blocked),
        .i_raddr(map_raddr), .o_rdata(map_rdata)
    );

    gbkj_ram #(.DEPTH(DDEPTH), .AW(AW), .DW(DW)) u_dist (
        .i_clk(i_clk), .i_we(dist_we), .i_waddr(dist_waddr), .i_wdata(dist_wdata),
        .i_raddr(dist_raddr), .o_rdata(dist_rdata)
    );

    gbkj_ram #(.DEPTH(QD), .AW(QIW), .DW(AW)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    gbkj_move_unit #(.RW(RW), .CW(CW)) u_move (
        .i_clk(i_clk), .i_en(mv_en), .i_row(cur_row), .i_col(cur_col), .i_move(r_move),
        .i_rows(rows_eff), .i_cols(cols_eff), .o_ok(mv_ok), .o_row(mv_row),
        .o_col(mv_col), .o_prod(mv_prod)
    );

    always_comb begin
        n_state     = r_state;
        n_load_pos  = r_load_pos;
        n_clr       = r_clr;
        n_head      = r_head;
        n_tail      = r_tail;
        n_cur       = r_cur;
        n_base      = r_base;
        n_move      = r_move;
        n_cand      = r_cand;
        n_scan_l    = r_scan_l;
        n_best      = r_best;
        n_out_valid = r_out_valid;
        n_min_moves = r_min_moves;

        map_we     = 1'b0;
        map_waddr  = r_load_pos[MW-1:0];
        map_raddr  = MW'(mv_prod + (RW+CW+1)'(mv_col));
        dist_we    = 1'b0;
        dist_waddr = r_cand;
        dist_wdata = DW'(r_base + 1'b1);
        dist_raddr = {cand_layer, mv_row, mv_col};
        q_we       = 1'b0;
        q_waddr    = r_tail[QIW-1:0];
        q_wdata    = r_cand;
        q_raddr    = r_head[QIW-1:0];
        mv_en      = 1'b0;

        // The result register frees as soon as the waiting beat is taken.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_LOAD: begin
                // Cells beyond the map store are dropped, as the load position saturates.
                if (in_fire) begin
                    if (32'(r_load_pos) < PLANE) begin
                        map_we     = 1'b1;
                        n_load_pos = LPW'(r_load_pos + 1'b1);
                    end
                    if (i_last_cell) begin
                        n_load_pos = '0;
                        n_clr      = '0;
                        n_state    = S_CLR;
                    end
                end
            end
            S_CLR: begin
                // One distance entry is zeroed per cycle.
                dist_we    = 1'b1;
                dist_waddr = r_clr;
                dist_wdata = '0;
                n_clr      = AW'(r_clr + 1'b1);
                if (32'(r_clr) == DDEPTH - 1) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                // Seed the start state: layer 0, top-left cell, stored distance one.
                dist_we    = 1'b1;
                dist_waddr = '0;
                dist_wdata = DW'(1);
                q_we       = 1'b1;
                q_waddr    = '0;
                q_wdata    = '0;
                n_head     = '0;
                n_tail     = QPW'(1);
                n_state    = S_POP;
            end
            S_POP: begin
                n_head  = QPW'(r_head + 1'b1);
                n_state = S_POPW;
            end
            S_POPW: begin
                n_cur      = q_rdata;
                dist_raddr = q_rdata;
                n_state    = S_BASE;
            end
            S_BASE: begin
                n_base  = dist_rdata;
                n_move  = (cur_layer < limit_eff) ? t_move'(0) : NUM_KNIGHT;
                n_state = S_CAND;
            end
            S_CAND: begin
                mv_en   = 1'b1;
                n_state = S_MAP;
            end
            S_MAP: begin
                n_cand  = {cand_layer, mv_row, mv_col};
                n_state = S_CHK;
            end
            S_CHK: begin
                // Enter the neighbor only if it is open and not yet visited in its layer.
                if (!map_rdata && dist_rdata == '0) begin
                    dist_we = 1'b1;
                    q_we    = 1'b1;
                    n_tail  = QPW'(r_tail + 1'b1);
                end
            end
            S_SCAN: begin
                dist_raddr = {r_scan_l, RW'(rows_eff - 1'b1), CW'(cols_eff - 1'b1)};
                n_state    = S_SCANW;
            end
            S_SCANW: begin
                if (dist_rdata != '0 && (r_best == '0 || dist_rdata < r_best)) begin
                    n_best = dist_rdata;
                end
                if (r_scan_l == limit_eff) begin
                    n_state = S_DONE;
                end else begin
                    n_scan_l = LW'(r_scan_l + 1'b1);
                    n_state  = S_SCAN;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_min_moves = (r_best == '0) ? '1 : 18'(r_best - 1'b1);
                    n_state     = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase

        // Step to the next move after an out-of-grid candidate or a finished check.
        if ((r_state == S_MAP && !mv_ok) || r_state == S_CHK) begin
            if (r_move == LAST_MOVE) begin
                if (n_head < n_tail) begin
                    n_state = S_POP;
                end else begin
                    n_scan_l = '0;
                    n_best   = '0;
                    n_state  = S_SCAN;
                end
            end else begin
                n_move  = t_move'(r_move + 1'b1);
                n_state = S_CAND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_load_pos  <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_pos  <= n_load_pos;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
        r_clr       <= n_clr;
        r_cur       <= n_cur;
        r_base      <= n_base;
        r_move      <= n_move;
        r_cand      <= n_cand;
        r_scan_l    <= n_scan_l;
        r_best      <= n_best;
        r_min_moves <= n_min_moves;
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_min_moves = $signed(r_min_moves);

    // The queue is never read past what has been written.
    `GBKJ_ASSERT_NOW(a_head_le_tail, 1'b1, r_head <= r_tail)
    // A new result appears only when a search has just finished.
    `GBKJ_ASSERT_NOW(a_result_from_done, $rose(r_out_valid), $past(r_state) == S_DONE)
    // A visited state never gets a zero distance, which would mark it unvisited.
    `GBKJ_ASSERT_NOW(a_visit_nonzero, dist_we && r_state == S_CHK, dist_wdata != '0)
endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the knight-jump grid search block.
`timescale 1ns / 100ps

module testbench;
    import gbkj_pkg::*;

    localparam int ROWS_MAX   = 64;
    localparam int COLS_MAX   = 64;
    localparam int LAYERS_MAX = 31;
    localparam int PLANE_SZ   = ROWS_MAX * COLS_MAX;
    localparam int STATE_SZ   = LAYERS_MAX * PLANE_SZ;
    localparam int WATCHDOG_LIMIT = 3000000;
    localparam int SETTLE_CYCLES  = 20;

    // Knight jumps, then the four neighbor steps.
    localparam int JUMP_DR [8] = '{1, 2, 2, 1, -1, -2, -2, -1};
    localparam int JUMP_DC [8] = '{2, 1, -1, -2, -2, -1, 1, 2};
    localparam int STEP_DR [4] = '{1, 0, -1, 0};
    localparam int STEP_DC [4] = '{0, 1, 0, -1};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_cell_blocked;
    logic               i_last_cell;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [17:0] o_min_moves;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    t_cfg_idx           i_cfg_index;
    logic [6:0]         i_cfg_data;

    grid_bfs_limited_knight_jumps i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cell_blocked(i_cell_blocked),
        .i_last_cell   (i_last_cell),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_min_moves   (o_min_moves),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Mirror of the block's registers and stores, updated on every accepted beat.
    logic [4:0]  mdl_jump_limit;
    logic [6:0]  mdl_grid_cols;
    logic [6:0]  mdl_grid_rows;
    bit          mdl_obstacles [PLANE_SZ];
    int unsigned mdl_load_pos;
    int unsigned layer_dist [STATE_SZ];
    int unsigned bfs_fifo [STATE_SZ];
    int unsigned bfs_head;
    int unsigned bfs_tail;

    logic signed [17:0] expected_moves [$];
    bit                 map_pattern [PLANE_SZ + 8];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int idle_cycles;
    int cells_sent;

    // Enter one search state if it is on the grid, open and not yet reached.
    function automatic void enter_state(int layer, int r, int c, int rows, int cols,
                                        int unsigned base);
        int unsigned idx;
        if (r < 0 || r >= rows || c < 0 || c >= cols) return;
        if (mdl_obstacles[r * cols + c]) return;
        idx = layer * PLANE_SZ + r * COLS_MAX + c;
        if (layer_dist[idx] != 0) return;
        layer_dist[idx] = base + 1;
        if (bfs_tail < STATE_SZ) begin
            bfs_fifo[bfs_tail] = idx;
            bfs_tail++;
        end
    endfunction

    // Least move count from the top-left to the bottom-right cell over all layers.
    function automatic logic signed [17:0] predict_moves();
        int rows;
        int cols;
        int limit;
        int unsigned best;
        int unsigned idx;
        int unsigned base;
        int layer;
        int r;
        int c;
        int unsigned v;
        rows  = (mdl_grid_rows < 1) ? 1 : (mdl_grid_rows > ROWS_MAX) ? ROWS_MAX : mdl_grid_rows;
        cols  = (mdl_grid_cols < 1) ? 1 : (mdl_grid_cols > COLS_MAX) ? COLS_MAX : mdl_grid_cols;
        limit = (mdl_jump_limit > LAYERS_MAX - 1) ? LAYERS_MAX - 1 : mdl_jump_limit;
        foreach (layer_dist[i]) layer_dist[i] = 0;
        best = 0;
        bfs_head = 0;
        bfs_tail = 1;
        bfs_fifo[0] = 0;
        layer_dist[0] = 1;
        while (bfs_head < bfs_tail) begin
            idx = bfs_fifo[bfs_head];
            bfs_head++;
            layer = idx / PLANE_SZ;
            r = (idx % PLANE_SZ) / COLS_MAX;
            c = idx % COLS_MAX;
            base = layer_dist[idx];
            if (layer < limit) begin
                for (int d = 0; d < 8; d++)
                    enter_state(layer + 1, r + JUMP_DR[d], c + JUMP_DC[d], rows, cols, base);
            end
            for (int d = 0; d < 4; d++)
                enter_state(layer, r + STEP_DR[d], c + STEP_DC[d], rows, cols, base);
        end
        for (int l = 0; l <= limit; l++) begin
            v = layer_dist[l * PLANE_SZ + (rows - 1) * COLS_MAX + (cols - 1)];
            if (v != 0 && (best == 0 || v < best)) best = v;
        end
        if (best == 0) return '1;
        return 18'(best - 1);
    endfunction

    // Update the mirror with an accepted map beat.
    function automatic void take_cell(bit blk, bit last);
        if (mdl_load_pos < PLANE_SZ) begin
            mdl_obstacles[mdl_load_pos] = blk;
            mdl_load_pos++;
        end
        if (last) begin
            expected_moves.push_back(predict_moves());
            mdl_load_pos = 0;
        end
    endfunction

    // Send one map beat; valid holds until the beat is taken.
    task automatic send_cell(input bit blk, input bit last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cell_blocked <= blk;
        i_last_cell    <= last;
        do @(posedge i_clk); while (!o_in_ready);
        take_cell(blk, last);
        cells_sent++;
    endtask

    task automatic go_quiet();
        @(negedge i_clk);
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [6:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_JUMP_LIMIT: mdl_jump_limit = data[4:0];
            CFG_GRID_COLS:  mdl_grid_cols  = data;
            CFG_GRID_ROWS:  mdl_grid_rows  = data;
            default: ;
        endcase
    endtask

    // Waits until every expected result has come back, then lets the block settle.
    task automatic wait_results();
        go_quiet();
        while (expected_moves.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [6:0] rows, input logic [6:0] cols,
                            input logic [6:0] limit);
        wait_results();
        write_reg(CFG_GRID_ROWS, rows);
        write_reg(CFG_GRID_COLS, cols);
        write_reg(CFG_JUMP_LIMIT, limit);
        go_quiet();
    endtask

    task automatic send_pattern(input int n);
        for (int i = 0; i < n; i++) send_cell(map_pattern[i], i == n - 1);
    endtask

    task automatic fill_pattern(input int n, input int blocked_pct);
        for (int i = 0; i < n; i++) map_pattern[i] = ($urandom_range(99) < blocked_pct);
    endtask

    // A 16 by 16 map with a few knight jumps allowed.
    task automatic test_large_grid();
        set_grid(7'd16, 7'd16, 7'd2);
        fill_pattern(256, 20);
        send_pattern(256);
    endtask

    // Corners of the grid: tiny grids, blocked start and target, clamped registers.
    task automatic test_corner_maps();
        set_grid(7'd1, 7'd1, 7'd0);
        map_pattern[0] = 1'b1;
        send_pattern(1);
        set_grid(7'd3, 7'd3, 7'd0);
        fill_pattern(9, 0);
        map_pattern[8] = 1'b1;
        send_pattern(9);
        set_grid(7'd2, 7'd2, 7'd0);
        fill_pattern(4, 0);
        map_pattern[0] = 1'b1;
        send_pattern(4);
        // A wall that only a knight jump can cross, with the limit saturated.
        set_grid(7'd4, 7'd4, 7'd31);
        fill_pattern(16, 0);
        for (int c = 0; c < 4; c++) map_pattern[4 + c] = 1'b1;
        send_pattern(16);
        set_grid(7'd4, 7'd4, 7'd0);
        send_pattern(16);
        // Out-of-range sizes clamp to a single column and a single row.
        set_grid(7'd127, 7'd0, 7'd1);
        fill_pattern(64, 0);
        send_pattern(64);
        set_grid(7'd0, 7'd100, 7'd30);
        fill_pattern(64, 10);
        send_pattern(64);
        // A short map keeps the earlier cells past its end.
        set_grid(7'd4, 7'd4, 7'd3);
        fill_pattern(3, 0);
        send_pattern(3);
    endtask

    // Random maps with random sizes and limits under one idling setting.
    task automatic test_random_maps(input int idle_pct, input int stall_pct,
                                    input int cell_budget);
        int stop_at;
        int rows;
        int cols;
        int limit;
        int n;
        stop_at = cells_sent + cell_budget;
        while (cells_sent < stop_at) begin
            rows  = ($urandom_range(9) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 12);
            cols  = ($urandom_range(9) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 12);
            limit = ($urandom_range(4) == 0) ? 30 : $urandom_range(0, 6);
            if (rows * cols > 200) limit = $urandom_range(0, 2);
            set_grid(7'(rows), 7'(cols), 7'(limit));
            send_idle_pct  = idle_pct;
            recv_stall_pct = stall_pct;
            n = rows * cols;
            fill_pattern(n, $urandom_range(0, 45));
            // Mostly keep the corners open so that most searches find a path.
            if ($urandom_range(3) != 0) begin
                map_pattern[0]     = 1'b0;
                map_pattern[n - 1] = 1'b0;
            end
            send_pattern(n);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no beat accepted for %0d cycles", idle_cycles);
                $display("grid_bfs_limited_knight_jumps regression: fail");
                $finish;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_moves.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: min_moves %0d", o_min_moves);
                end else begin
                    if (o_min_moves !== expected_moves[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("min_moves mismatch: expected %0d, actual %0d",
                                     expected_moves[0], o_min_moves);
                    end
                    void'(expected_moves.pop_front());
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_cell_blocked = 1'b0;
        i_last_cell    = 1'b0;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_JUMP_LIMIT;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        idle_cycles    = 0;
        cells_sent     = 0;
        mdl_jump_limit = '0;
        mdl_grid_cols  = 7'd64;
        mdl_grid_rows  = 7'd64;
        mdl_load_pos   = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_large_grid();
        test_corner_maps();
        // Idling phases: none, sender gaps, receiver stalls, then both.
        test_random_maps(0, 0, 350);
        test_random_maps(85, 0, 350);
        test_random_maps(0, 85, 350);
        test_random_maps(30, 30, 350);

        wait_results();
        if (mismatches == 0) begin
            $display("grid_bfs_limited_knight_jumps regression: pass");
        end else begin
            $display("grid_bfs_limited_knight_jumps regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/gbkj_pkg.sv
src/gbkj_ram.sv
src/gbkj_move_unit.sv
src/grid_bfs_limited_knight_jumps.sv
tb/testbench.sv
